// ----- sv/adaptive_threshold_peak_hold_top_assert.svh -----
// Assertion macros shared by the adaptive threshold peak hold RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ADAPTIVE_THRESHOLD_PEAK_HOLD_TOP_ASSERT_SVH
`define ADAPTIVE_THRESHOLD_PEAK_HOLD_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ATPH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atph assertion failed");

// next-cycle implication, disabled in reset
`define ATPH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atph assertion failed");

`endif

// ----- sv/atph_pkg.sv -----
// Shared types and constants for the adaptive threshold peak hold block.
// No dependencies.
package atph_pkg;

    localparam int unsigned SAMPLE_W   = 24;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned MULT_W     = 8;
    localparam int unsigned HOLD_W     = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned WINDOW_DEF = 20;

    localparam logic [MULT_W-1:0] MULT_RST = MULT_W'(24);   // 1.5 in Q4.4
    localparam logic [HOLD_W-1:0] HOLD_RST = HOLD_W'(5000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD_MULT = CFG_IDX_W'(0),
        REG_HOLD_MS        = CFG_IDX_W'(1)
    } t_cfg_reg;

    typedef struct packed {
        logic [TIME_W-1:0]   now_ms;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] held_peak;
        logic                above_threshold;
        logic                peak_cleared;
    } t_out_item;

endpackage

// ----- sv/atph_stream_if.sv -----
// Valid/ready stream channel carrying one payload beat per handshake.
// Payload type is a parameter; used with the structs in atph_pkg.
interface atph_stream_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/atph_cell.sv -----
// One window cell: holds one sample and passes it to the next cell on shift.
// Depends on atph_pkg.
module atph_cell
    import atph_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_shift,
    input  logic [SAMPLE_W-1:0] i_d,
    output logic [SAMPLE_W-1:0] o_q
);

    logic [SAMPLE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ----- sv/atph_window.sv -----
// Sample window as a chain of cells, plus running sum and fill count.
// Depends on atph_pkg, atph_cell and the assertion macro header.
`include "adaptive_threshold_peak_hold_top_assert.svh"

module atph_window
    import atph_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF,
    localparam int unsigned CW    = $clog2(WINDOW + 1),
    localparam int unsigned SW    = SAMPLE_W + CW
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic [SAMPLE_W-1:0] o_newest,
    output logic [CW-1:0]       o_count,
    output logic [SW-1:0]       o_sum
);

    logic [SAMPLE_W-1:0] w_q [WINDOW];
    logic [CW-1:0]       r_fill;
    logic [CW-1:0]       n_fill;
    logic [SW-1:0]       r_sum;
    logic [SW-1:0]       n_sum;
    logic                w_full;

    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        if (k == 0) begin : g_head
            atph_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_shift),
                .i_d     (i_sample),
                .o_q     (w_q[k])
            );
        end else begin : g_body
            atph_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_shift),
                .i_d     (w_q[k-1]),
                .o_q     (w_q[k])
            );
        end
    end

    assign w_full = (r_fill == CW'(WINDOW));

    // the sample falling off the tail is dropped from the sum once full
    always_comb begin
        n_sum  = r_sum + SW'(i_sample);
        n_fill = r_fill;
        if (w_full) begin
            n_sum = n_sum - SW'(w_q[WINDOW-1]);
        end else begin
            n_fill = r_fill + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_sum  <= '0;
        end else if (i_shift) begin
            r_fill <= n_fill;
            r_sum  <= n_sum;
        end
    end

    assign o_newest = w_q[0];
    assign o_count  = r_fill;
    assign o_sum    = r_sum;

    `ATPH_ASSERT_IMP(a_fill_range, i_clk, i_rst_n, 1'b1, r_fill <= CW'(WINDOW))
    `ATPH_ASSERT_NXT(a_fill_grow, i_clk, i_rst_n, i_shift && !w_full, r_fill == $past(r_fill) + CW'(1))
    `ATPH_ASSERT_NXT(a_sum_hold, i_clk, i_rst_n, !i_shift, $stable(r_sum) && $stable(r_fill))

endmodule

// ----- sv/atph_detect.sv -----
// Threshold products, compare, peak register and output register.
// Depends on atph_pkg, atph_stream_if and the assertion macro header.
`include "adaptive_threshold_peak_hold_top_assert.svh"

module atph_detect
    import atph_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF,
    localparam int unsigned CW    = $clog2(WINDOW + 1),
    localparam int unsigned SW    = SAMPLE_W + CW,
    localparam int unsigned PA_W  = SAMPLE_W + CW,
    localparam int unsigned PB_W  = SW + MULT_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [CW-1:0]       i_count,
    input  logic [SW-1:0]       i_sum,
    input  logic                i_cleared,
    input  logic [MULT_W-1:0]   i_mult,
    atph_stream_if.source       o_out
);

    logic                r_v2;
    logic [SAMPLE_W-1:0] r_sample2;
    logic [PA_W-1:0]     r_pa;
    logic [PB_W-1:0]     r_pb;
    logic                r_cleared2;
    logic                r_vo;
    t_out_item           r_out;
    logic [SAMPLE_W-1:0] r_peak;
    logic [SAMPLE_W-1:0] n_peak;
    logic                w_above;
    logic                w_o_ready;
    logic                w_s2_ready;

    assign w_o_ready  = !r_vo || o_out.ready;
    assign w_s2_ready = !r_v2 || w_o_ready;
    assign o_ready    = w_s2_ready;

    // stage 2: sample*count and sum*mult
    always_ff @(posedge i_clk) begin
        if (w_s2_ready && i_valid) begin
            r_sample2  <= i_sample;
            r_pa       <= PA_W'(i_sample) * PA_W'(i_count);
            r_pb       <= PB_W'(i_sum) * PB_W'(i_mult);
            r_cleared2 <= i_cleared;
        end
    end

    // sample*count*16 > sum*mult
    assign w_above = {4'b0, r_pa, 4'b0} > r_pb;

    always_comb begin
        n_peak = r_peak;
        if (w_above) begin
            n_peak = r_sample2;
        end
        if (r_cleared2) begin
            n_peak = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2   <= 1'b0;
            r_vo   <= 1'b0;
            r_peak <= '0;
        end else begin
            if (w_s2_ready) begin
                r_v2 <= i_valid;
            end
            if (w_o_ready) begin
                r_vo <= r_v2;
                if (r_v2) begin
                    r_peak <= n_peak;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_ready && r_v2) begin
            r_out.held_peak       <= n_peak;
            r_out.above_threshold <= w_above;
            r_out.peak_cleared    <= r_cleared2;
        end
    end

    assign o_out.valid   = r_vo;
    assign o_out.payload = r_out;

    `ATPH_ASSERT_IMP(a_clear_zero, i_clk, i_rst_n, r_vo && r_out.peak_cleared, r_out.held_peak == '0)
    `ATPH_ASSERT_IMP(a_above_nonzero, i_clk, i_rst_n, r_vo && r_out.above_threshold && !r_out.peak_cleared, r_out.held_peak != '0)
    `ATPH_ASSERT_IMP(a_peak_match, i_clk, i_rst_n, r_vo, r_peak == r_out.held_peak)

endmodule

// ----- sv/adaptive_threshold_peak_hold_top.sv -----
// Adaptive threshold peak hold: takes one sample beat per cycle when not stalled and returns
// one result beat per sample. The rate is set by the running-sum update in the window cell
// chain, which completes in the cycle a beat is accepted; the two multiplies and the compare
// follow in registered stages. Each stage holds under output backpressure only while it is
// full, so bubbles still fill. Configuration (threshold multiplier in Q4.4, hold time in ms)
// must be written only while the block is idle, which the block does not enforce.
// Depends on atph_pkg, atph_stream_if, atph_window, atph_cell and atph_detect.
module adaptive_threshold_peak_hold_top
    import atph_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF,
    localparam int unsigned CW    = $clog2(WINDOW + 1),
    localparam int unsigned SW    = SAMPLE_W + CW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    atph_stream_if.sink           i_in,
    atph_stream_if.source         o_out
);

    logic [MULT_W-1:0]   r_mult;
    logic [HOLD_W-1:0]   r_hold;
    logic [TIME_W-1:0]   r_deadline;
    logic                r_v1;
    logic                r_cleared1;
    logic                w_det_ready;
    logic                w_s1_ready;
    logic                w_accept;
    logic                w_timeout;
    logic [SAMPLE_W-1:0] w_newest;
    logic [CW-1:0]       w_count;
    logic [SW-1:0]       w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= MULT_RST;
            r_hold <= HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESHOLD_MULT: r_mult <= i_cfg_data[MULT_W-1:0];
                REG_HOLD_MS:        r_hold <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_s1_ready = !r_v1 || w_det_ready;
    assign w_accept   = i_in.valid && w_s1_ready;
    assign i_in.ready = w_s1_ready;
    assign w_timeout  = i_in.payload.now_ms > r_deadline;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_deadline <= '0;
        end else begin
            if (w_s1_ready) begin
                r_v1 <= i_in.valid;
            end
            if (w_accept && w_timeout) begin
                r_deadline <= i_in.payload.now_ms + TIME_W'(r_hold);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cleared1 <= w_timeout;
        end
    end

    // window state doubles as the stage-1 payload: it only moves on accept
    atph_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_accept),
        .i_sample (i_in.payload.sample),
        .o_newest (w_newest),
        .o_count  (w_count),
        .o_sum    (w_sum)
    );

    atph_detect #(
        .WINDOW (WINDOW)
    ) u_detect (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_v1),
        .o_ready   (w_det_ready),
        .i_sample  (w_newest),
        .i_count   (w_count),
        .i_sum     (w_sum),
        .i_cleared (r_cleared1),
        .i_mult    (r_mult),
        .o_out     (o_out)
    );

endmodule

// ----- tb/tb_adaptive_threshold_peak_hold_top.sv -----
// Testbench for adaptive_threshold_peak_hold_top: directed and random sample streams,
// checked beat by beat against a local model of the windowed noise floor and peak hold.
// Depends on atph_pkg, atph_stream_if and the block's RTL.
module tb_adaptive_threshold_peak_hold_top
    import atph_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
    localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX  = {SAMPLE_W{1'b1}};
    localparam int unsigned          IDLE_PCT    = 36;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    atph_stream_if #(.T_PAYLOAD(t_in_item))  in_ch ();
    atph_stream_if #(.T_PAYLOAD(t_out_item)) out_ch ();

    adaptive_threshold_peak_hold_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // model state
    logic [SAMPLE_W-1:0] win_mem [WINDOW_DEF];
    int unsigned         wr_pos;
    bit                  win_full;
    logic [63:0]         win_sum;
    logic [SAMPLE_W-1:0] peak_q;
    logic [TIME_W-1:0]   deadline_q;
    logic [MULT_W-1:0]   mult_q;
    logic [HOLD_W-1:0]   hold_q;

    t_out_item           predicted_peaks_q [$];
    int unsigned         fail_cnt;
    bit                  src_idle_en;
    bit                  snk_idle_en;
    int unsigned         holdoff_left;
    logic [TIME_W-1:0]   now_cur;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL adaptive_threshold_peak_hold_top");
        $finish;
    end

    function automatic t_out_item predict_peak(input logic [SAMPLE_W-1:0] smp,
                                               input logic [TIME_W-1:0] now);
        t_out_item   res;
        logic [63:0] lhs;
        logic [63:0] rhs;
        int unsigned cnt;
        if (win_full) win_sum = win_sum - 64'(win_mem[wr_pos]);
        win_mem[wr_pos] = smp;
        win_sum = win_sum + 64'(smp);
        wr_pos++;
        if (wr_pos == WINDOW_DEF) begin
            wr_pos   = 0;
            win_full = 1'b1;
        end
        cnt = win_full ? WINDOW_DEF : wr_pos;
        lhs = 64'(smp) * 64'(cnt) * 64'd16;
        rhs = win_sum * 64'(mult_q);
        res.above_threshold = (lhs > rhs);
        res.peak_cleared    = 1'b0;
        if (res.above_threshold) peak_q = smp;
        // exceed and timeout on the same beat: peak is taken, then cleared
        if (now > deadline_q) begin
            peak_q     = '0;
            deadline_q = now + TIME_W'(hold_q);
            res.peak_cleared = 1'b1;
        end
        res.held_peak = peak_q;
        return res;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] now);
        @(negedge i_clk);
        while (src_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= '{now_ms: now, sample: smp};
        do @(posedge i_clk); while (!in_ch.ready);
        predicted_peaks_q.push_back(predict_peak(smp, now));
    endtask

    // lower valid and wait for the pipeline to empty
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (predicted_peaks_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_THRESHOLD_MULT: mult_q = data[MULT_W-1:0];
            REG_HOLD_MS:        hold_q = data[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample(input logic [SAMPLE_W-1:0] base);
        int unsigned r;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        if (r < 10) v = $urandom() & 32'(SAMPLE_MAX);
        else if (r < 25) v = 32'(base) * $urandom_range(2, 4) + $urandom_range(0, 4095);
        else v = 32'(base) + $urandom_range(0, 32'(base) / 8 + 16);
        return (v > 32'(SAMPLE_MAX)) ? SAMPLE_MAX : v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] next_now();
        int unsigned r;
        r = $urandom_range(0, 199);
        if (r < 2) now_cur = $urandom();
        else if (r < 4) now_cur = 32'hFFFF_F000 + $urandom_range(0, 4095);
        else if (r < 10) now_cur = now_cur + $urandom_range(0, 70000);
        else now_cur = now_cur + $urandom_range(0, 40);
        return now_cur;
    endfunction

    task automatic test_defaults();
        send_sample('0, 32'd0);
        send_sample(SAMPLE_MAX, 32'd1);      // exceed and timeout together
        send_sample(24'd10, 32'd2);
        send_sample(SAMPLE_MAX, 32'd3);
        send_sample(24'd1, 32'd5001);        // exactly at the deadline, no clear
        send_sample(24'd2, 32'd5002);
        wait_idle();
    endtask

    task automatic test_zero_mult();
        write_reg(REG_THRESHOLD_MULT, 16'h0000);
        send_sample('0, 32'd5003);
        send_sample(24'd1, 32'd5004);
        send_sample(24'h800000, 32'd5005);
        wait_idle();
    endtask

    task automatic test_max_mult();
        write_reg(REG_THRESHOLD_MULT, 16'hFFFF);   // upper byte is dropped
        write_reg(REG_HOLD_MS, 16'h0000);
        send_sample(SAMPLE_MAX, 32'd6000);
        send_sample('0, 32'd6000);
        send_sample(SAMPLE_MAX, 32'd6001);
        wait_idle();
    endtask

    task automatic test_deadline_wrap();
        write_reg(REG_HOLD_MS, 16'hFFFF);
        write_reg(REG_THRESHOLD_MULT, 16'h0018);
        send_sample(24'h123456, 32'hFFFF_FFF0);   // deadline wraps past zero
        send_sample(24'd5, 32'hFFFF_FFFF);
        send_sample(24'd7, 32'h0000_0010);
        send_sample(24'd9, 32'h0001_0000);
        wait_idle();
    endtask

    task automatic test_spare_index();
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h0000);
        send_sample(24'hABCDEF, 32'h0001_0010);
        send_sample(24'h000400, 32'h0001_0020);
        wait_idle();
    endtask

    task automatic test_backpressure();
        logic [SAMPLE_W-1:0] base;
        src_idle_en  = 1'b0;
        base         = $urandom_range(0, 24'h0FFFFF);
        holdoff_left = 80;
        repeat (40) send_sample(rand_sample(base), next_now());
        wait_idle();
        src_idle_en = 1'b1;
    endtask

    task automatic test_random_phases();
        logic [SAMPLE_W-1:0] base;
        logic [MULT_W-1:0]   mult_v;
        logic [HOLD_W-1:0]   hold_v;
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                1: begin mult_v = '0;  hold_v = '0;  end
                2: begin mult_v = '1;  hold_v = '1;  end
                default: begin
                    mult_v = $urandom_range(0, 255);
                    hold_v = ($urandom_range(0, 3) == 0) ? HOLD_W'($urandom())
                                                         : HOLD_W'($urandom_range(0, 2000));
                end
            endcase
            write_reg(REG_THRESHOLD_MULT, {8'($urandom()), mult_v});
            write_reg(REG_HOLD_MS, hold_v);
            // first phase runs without any idling on either side
            src_idle_en = (ph != 0);
            snk_idle_en = (ph != 0);
            base = $urandom_range(0, 24'h3FFFFF);
            repeat (104) send_sample(rand_sample(base), next_now());
            wait_idle();
        end
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_left != 0) begin
                out_ch.ready <= 1'b0;
                holdoff_left--;
            end else begin
                out_ch.ready <= !(snk_idle_en && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (predicted_peaks_q.size() == 0) begin
                $display("%0t: result beat with nothing pending: got %h", $time, out_ch.payload);
                fail_cnt++;
            end else begin
                exp_item = predicted_peaks_q.pop_front();
                if (out_ch.payload.held_peak !== exp_item.held_peak) begin
                    $display("%0t: held_peak exp %h got %h", $time,
                             exp_item.held_peak, out_ch.payload.held_peak);
                    fail_cnt++;
                end
                if (out_ch.payload.above_threshold !== exp_item.above_threshold) begin
                    $display("%0t: above_threshold exp %b got %b", $time,
                             exp_item.above_threshold, out_ch.payload.above_threshold);
                    fail_cnt++;
                end
                if (out_ch.payload.peak_cleared !== exp_item.peak_cleared) begin
                    $display("%0t: peak_cleared exp %b got %b", $time,
                             exp_item.peak_cleared, out_ch.payload.peak_cleared);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        fail_cnt      = 0;
        src_idle_en   = 1'b1;
        snk_idle_en   = 1'b1;
        holdoff_left  = 0;
        now_cur       = 32'h0002_0000;
        wr_pos        = 0;
        win_full      = 1'b0;
        win_sum       = '0;
        peak_q        = '0;
        deadline_q    = '0;
        mult_q        = MULT_RST;
        hold_q        = HOLD_RST;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_defaults();
        test_zero_mult();
        test_max_mult();
        test_deadline_wrap();
        test_spare_index();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("PASS adaptive_threshold_peak_hold_top");
        end else begin
            $display("FAIL adaptive_threshold_peak_hold_top");
        end
        $finish;
    end

endmodule
